### rtl/rru_pkg.sv
// Shared types, operation codes and helpers for the register rename unit.
// Depends on nothing; every other file in rtl/ imports it.
package rru_pkg;

    localparam int THREADS     = 2;
    localparam int ARCH_REGS   = 32;
    localparam int NUM_PTAGS   = 128;
    localparam int ROB_DEPTH   = 16;
    localparam int MAPQ_DEPTH  = 32;
    localparam int CHUNK       = 8;
    localparam int TAG_CHUNKS  = NUM_PTAGS / CHUNK;
    localparam int SLOT_CHUNKS = MAPQ_DEPTH / CHUNK;

    localparam logic [2:0] FN_SRC    = 3'd0;
    localparam logic [2:0] FN_ALLOC  = 3'd1;
    localparam logic [2:0] FN_CKPT   = 3'd2;
    localparam logic [2:0] FN_RETIRE = 3'd3;
    localparam logic [2:0] FN_FLUSH  = 3'd4;
    localparam logic [2:0] FN_STALL  = 3'd5;
    localparam logic [2:0] FN_COMMIT = 3'd6;

    typedef struct packed {
        logic [6:0] tag;
        logic       tvld;
        logic       st;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [4:0] areg;
        logic [6:0] ptag;
        logic [3:0] bidx;
        logic       wrap;
        logic [5:0] rid;
    } mq_ent_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_ALLOC_TAG,
        ST_ALLOC_SLOT,
        ST_ALLOC_WR,
        ST_CKPT,
        ST_RET_CHK,
        ST_RET_MQ,
        ST_RET_CM,
        ST_FL_COPY,
        ST_FL_CHK,
        ST_FL_MQ,
        ST_EMIT
    } state_t;

    // Age order on index plus wrap bit.
    function automatic logic age_le(input logic [3:0] ai, input logic aw,
                                    input logic [3:0] bi, input logic bw);
        if (aw == bw)
        begin
            return ai <= bi;
        end
        return ai > bi;
    endfunction

    // Position of the lowest set bit of an eight-bit group.
    function automatic logic [2:0] low_one(input logic [CHUNK-1:0] v);
        logic [2:0] p;
        p = 3'd0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

### rtl/rru_obuf.sv
// Output register for result beats of the register rename unit.
// Depends on rru_pkg for the result type.
module rru_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rru_pkg::res_t push_res,
    output logic          can_push,
    input  logic          stall,
    output logic          valid,
    output rru_pkg::res_t res
);
    import rru_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign can_push = !valid_reg || !stall;
    assign valid    = valid_reg;
    assign res      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

endmodule

### rtl/register_rename_unit_top.sv
// Top level of the register rename unit: sequencer, map memories, free bitmap,
// checkpoint store and map queue. Depends on rru_pkg and rru_obuf.
//
// Usage: an operation beat enters on in_valid/in_stall with its fields; result
// beats leave on out_valid/out_stall through one output register. in_stall is
// high whenever an operation is in progress, so one operation is handled at a
// time. After acceptance a sequencer drives one read port and one write port
// of each memory and one scan step per cycle:
//   lookups: both maps are read, then the result beat is formed and
//   queued; the next operation beat is taken once the sequencer is idle;
//   stall check and unused codes: the result beat is formed at dispatch;
//   allocation: free-tag scan, then queue-slot scan, each in groups of
//   eight, then the write;
//   checkpoint: copying the map one register a cycle;
//   retire: a scan of the 32 queue slots, one beat per tag;
//   flush: map restore when needed, then the slot scan.
// The map memories read one entry per cycle.
// When out_stall is high the sequencer holds at the next result beat; the
// queued beat stays unchanged. Reset restores the identity maps through valid
// flags and the free bitmap directly, at once; no clearing pass is needed.
module register_rename_unit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic       thread,
    input  logic [4:0] arch_reg,
    input  logic [3:0] block_id,
    input  logic       block_wrap,
    input  logic [5:0] inst_rid,
    input  logic       flush_by_block,
    input  logic [5:0] need_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] phys_tag,
    output logic       tag_valid,
    output logic       stall_res,
    output logic       last
);
    import rru_pkg::*;

    localparam res_t RES_LAST = '{tag: 7'd0, tvld: 1'b0, st: 1'b0, last: 1'b1};

    state_t state_reg, state_next;

    logic [2:0] func_reg;
    logic       thr_reg;
    logic [4:0] ar_reg;
    logic [3:0] bi_reg;
    logic       bw_reg;
    logic [5:0] rid_reg;
    logic       byblk_reg;
    logic [5:0] need_reg;

    logic [5:0]           cnt_reg, cnt_next;
    logic [NUM_PTAGS-1:0] fb_reg, fb_next;
    logic [7:0]           fcnt_reg, fcnt_next;
    logic [63:0]          qvld_reg, qvld_next;
    logic [5:0]           qfc_reg [THREADS];
    logic [5:0]           qfc_next [THREADS];
    logic [63:0]          spec_vld_reg, spec_vld_next;
    logic [63:0]          cm_vld_reg, cm_vld_next;
    logic [31:0]          cvalid_reg, cvalid_next;
    logic [3:0]           rp_idx_reg [THREADS];
    logic [3:0]           rp_idx_next [THREADS];
    logic                 rp_wrap_reg [THREADS];
    logic                 rp_wrap_next [THREADS];
    logic [6:0]           tag_reg, tag_next;
    logic [4:0]           slot_reg, slot_next;
    logic                 pend_reg, pend_next;
    logic [6:0]           pend_tag_reg, pend_tag_next;
    logic                 src_ck_reg, src_ck_next;
    res_t                 res_reg, res_next;

    // Memories and their ports.
    logic [6:0] spec_mem [64];
    logic [6:0] cm_mem [64];
    logic [6:0] ckpt_mem [1024];
    mq_ent_t    mq_mem [64];

    logic       spec_we, spec_re, cm_we, cm_re, ckpt_we, ckpt_re, mq_we, mq_re;
    logic [5:0] spec_waddr, spec_raddr, cm_waddr, cm_raddr, mq_waddr, mq_raddr;
    logic [6:0] spec_wdata, cm_wdata, ckpt_wdata;
    logic [9:0] ckpt_waddr, ckpt_raddr;
    mq_ent_t    mq_wdata;

    logic [6:0] spec_rd_reg, cm_rd_reg, ckpt_rd_reg;
    logic       spec_rv_reg, cm_rv_reg;
    logic [5:0] spec_ra_reg, cm_ra_reg;
    mq_ent_t    mq_rd_reg;

    logic [6:0] spec_val, cm_val;
    logic       accept, can_push, push;
    res_t       push_res, obuf_res;

    logic [3:0]       y_idx;
    logic             y_wrap;
    logic             restore;
    logic [CHUNK-1:0] tag_chunk, slot_chunk;
    logic             slot_vld, mq_same, mq_kill;
    logic [5:0]       cnt_m1;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // An entry never written holds its reset value, the identity map.
    assign spec_val = spec_rv_reg ? spec_rd_reg : {1'b0, spec_ra_reg};
    assign cm_val   = cm_rv_reg ? cm_rd_reg : {1'b0, cm_ra_reg};

    assign y_idx   = bi_reg - 4'd1;
    assign y_wrap  = (bi_reg == 4'd0) ? !bw_reg : bw_reg;
    assign restore = age_le(y_idx, y_wrap, rp_idx_reg[thr_reg], rp_wrap_reg[thr_reg]);

    assign tag_chunk  = fb_reg[{cnt_reg[3:0], 3'b000} +: CHUNK];
    assign slot_chunk = ~qvld_reg[{thr_reg, cnt_reg[1:0], 3'b000} +: CHUNK];
    assign slot_vld   = qvld_reg[{thr_reg, cnt_reg[4:0]}];
    assign mq_same    = (mq_rd_reg.bidx == bi_reg) && (mq_rd_reg.wrap == bw_reg);
    assign mq_kill    = (!byblk_reg && mq_same) ? (rid_reg <= mq_rd_reg.rid)
                      : age_le(bi_reg, bw_reg, mq_rd_reg.bidx, mq_rd_reg.wrap);
    assign cnt_m1     = cnt_reg - 6'd1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (func_reg) inside
                    FN_SRC, FN_COMMIT: state_next = ST_LOOKUP;
                    FN_ALLOC:          state_next = ST_ALLOC_TAG;
                    FN_CKPT:           state_next = ST_CKPT;
                    FN_RETIRE:         state_next = ST_RET_CHK;
                    FN_FLUSH:          state_next = restore ? ST_FL_COPY : ST_FL_CHK;
                    default:           state_next = ST_EMIT;
                endcase
            end
            ST_LOOKUP: state_next = ST_EMIT;
            ST_ALLOC_TAG:
            begin
                if (|tag_chunk)
                begin
                    state_next = ST_ALLOC_SLOT;
                end
                else if (cnt_reg == 6'(TAG_CHUNKS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ALLOC_SLOT:
            begin
                if (|slot_chunk)
                begin
                    state_next = ST_ALLOC_WR;
                end
                else if (cnt_reg == 6'(SLOT_CHUNKS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_ALLOC_WR: state_next = ST_EMIT;
            ST_CKPT:
            begin
                if (cnt_reg == 6'(ARCH_REGS))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RET_CHK:
            begin
                if (cnt_reg == 6'(MAPQ_DEPTH))
                begin
                    state_next = ST_EMIT;
                end
                else if (slot_vld)
                begin
                    state_next = ST_RET_MQ;
                end
            end
            ST_RET_MQ: state_next = mq_same ? ST_RET_CM : ST_RET_CHK;
            ST_RET_CM:
            begin
                if (!pend_reg || can_push)
                begin
                    state_next = ST_RET_CHK;
                end
            end
            ST_FL_COPY:
            begin
                if (cnt_reg == 6'(ARCH_REGS))
                begin
                    state_next = ST_FL_CHK;
                end
            end
            ST_FL_CHK:
            begin
                if (cnt_reg == 6'(MAPQ_DEPTH))
                begin
                    state_next = ST_EMIT;
                end
                else if (slot_vld)
                begin
                    state_next = ST_FL_MQ;
                end
            end
            ST_FL_MQ: state_next = ST_FL_CHK;
            ST_EMIT:
            begin
                if (can_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        cnt_next      = cnt_reg;
        fb_next       = fb_reg;
        fcnt_next     = fcnt_reg;
        qvld_next     = qvld_reg;
        qfc_next      = qfc_reg;
        spec_vld_next = spec_vld_reg;
        cm_vld_next   = cm_vld_reg;
        cvalid_next   = cvalid_reg;
        rp_idx_next   = rp_idx_reg;
        rp_wrap_next  = rp_wrap_reg;
        tag_next      = tag_reg;
        slot_next     = slot_reg;
        pend_next     = pend_reg;
        pend_tag_next = pend_tag_reg;
        src_ck_next   = src_ck_reg;
        res_next      = res_reg;
        spec_we = 1'b0; spec_re = 1'b0; cm_we = 1'b0; cm_re = 1'b0;
        ckpt_we = 1'b0; ckpt_re = 1'b0; mq_we = 1'b0; mq_re = 1'b0;
        spec_waddr = {thr_reg, ar_reg};
        spec_raddr = {thr_reg, ar_reg};
        cm_waddr   = {thr_reg, mq_rd_reg.areg};
        cm_raddr   = {thr_reg, ar_reg};
        mq_waddr   = {thr_reg, slot_reg};
        mq_raddr   = {thr_reg, cnt_reg[4:0]};
        spec_wdata = tag_reg;
        cm_wdata   = mq_rd_reg.ptag;
        ckpt_waddr = {thr_reg, bi_reg, cnt_m1[4:0]};
        ckpt_raddr = {thr_reg, y_idx, cnt_reg[4:0]};
        ckpt_wdata = spec_val;
        mq_wdata   = '{areg: ar_reg, ptag: tag_reg, bidx: bi_reg, wrap: bw_reg,
                       rid: rid_reg};
        push     = 1'b0;
        push_res = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next  = 6'd0;
                pend_next = 1'b0;
            end
            ST_DISPATCH:
            begin
                res_next = RES_LAST;
                case (func_reg) inside
                    FN_SRC, FN_COMMIT:
                    begin
                        spec_re = 1'b1;
                        cm_re   = 1'b1;
                    end
                    FN_FLUSH:
                    begin
                        if (restore)
                        begin
                            rp_idx_next[thr_reg]  = y_idx;
                            rp_wrap_next[thr_reg] = y_wrap;
                            src_ck_next = cvalid_reg[{thr_reg, y_idx}];
                        end
                    end
                    FN_STALL:
                    begin
                        res_next.st = (fcnt_reg < {2'b00, need_reg})
                                   || (qfc_reg[thr_reg] < need_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LOOKUP:
            begin
                res_next = '{tag: (func_reg == FN_SRC) ? spec_val : cm_val,
                             tvld: 1'b1, st: 1'b0, last: 1'b1};
            end
            ST_ALLOC_TAG:
            begin
                if (|tag_chunk)
                begin
                    tag_next = {cnt_reg[3:0], low_one(tag_chunk)};
                    cnt_next = 6'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ALLOC_SLOT:
            begin
                if (|slot_chunk)
                begin
                    slot_next = {cnt_reg[1:0], low_one(slot_chunk)};
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ALLOC_WR:
            begin
                fb_next[tag_reg] = 1'b0;
                fcnt_next = fcnt_reg - 8'd1;
                spec_we = 1'b1;
                spec_vld_next[{thr_reg, ar_reg}] = 1'b1;
                mq_we = 1'b1;
                qvld_next[{thr_reg, slot_reg}] = 1'b1;
                qfc_next[thr_reg] = qfc_reg[thr_reg] - 6'd1;
                res_next = '{tag: tag_reg, tvld: 1'b1, st: 1'b0, last: 1'b1};
            end
            ST_CKPT:
            begin
                // Read register n while register n-1 goes into the store.
                spec_raddr = {thr_reg, cnt_reg[4:0]};
                spec_re = (cnt_reg != 6'(ARCH_REGS));
                ckpt_we = (cnt_reg != 6'd0);
                if (cnt_reg == 6'(ARCH_REGS))
                begin
                    cvalid_next[{thr_reg, bi_reg}] = 1'b1;
                    rp_idx_next[thr_reg]  = bi_reg;
                    rp_wrap_next[thr_reg] = bw_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_RET_CHK:
            begin
                if (cnt_reg == 6'(MAPQ_DEPTH))
                begin
                    res_next = pend_reg
                             ? '{tag: pend_tag_reg, tvld: 1'b1, st: 1'b0, last: 1'b1}
                             : RES_LAST;
                end
                else if (slot_vld)
                begin
                    mq_re = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_RET_MQ:
            begin
                cm_raddr = {thr_reg, mq_rd_reg.areg};
                if (mq_same)
                begin
                    cm_re = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_RET_CM:
            begin
                // The previous released tag leaves only once a later one is
                // known, so that the final beat can carry last.
                if (!pend_reg || can_push)
                begin
                    push     = pend_reg;
                    push_res = '{tag: pend_tag_reg, tvld: 1'b1, st: 1'b0, last: 1'b0};
                    pend_next     = 1'b1;
                    pend_tag_next = cm_val;
                    if (!fb_reg[cm_val])
                    begin
                        fb_next[cm_val] = 1'b1;
                        fcnt_next = fcnt_reg + 8'd1;
                    end
                    cm_we = 1'b1;
                    cm_vld_next[{thr_reg, mq_rd_reg.areg}] = 1'b1;
                    qvld_next[{thr_reg, cnt_reg[4:0]}] = 1'b0;
                    qfc_next[thr_reg] = qfc_reg[thr_reg] + 6'd1;
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_FL_COPY:
            begin
                cm_raddr = {thr_reg, cnt_reg[4:0]};
                cm_re    = (cnt_reg != 6'(ARCH_REGS));
                ckpt_re  = (cnt_reg != 6'(ARCH_REGS));
                spec_waddr = {thr_reg, cnt_m1[4:0]};
                spec_wdata = src_ck_reg ? ckpt_rd_reg : cm_val;
                if (cnt_reg != 6'd0)
                begin
                    spec_we = 1'b1;
                    spec_vld_next[{thr_reg, cnt_m1[4:0]}] = 1'b1;
                end
                cnt_next = (cnt_reg == 6'(ARCH_REGS)) ? 6'd0 : cnt_reg + 6'd1;
            end
            ST_FL_CHK:
            begin
                if (cnt_reg == 6'(MAPQ_DEPTH))
                begin
                    res_next = RES_LAST;
                end
                else if (slot_vld)
                begin
                    mq_re = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_FL_MQ:
            begin
                spec_waddr = {thr_reg, mq_rd_reg.areg};
                spec_wdata = mq_rd_reg.ptag;
                if (mq_kill)
                begin
                    qvld_next[{thr_reg, cnt_reg[4:0]}] = 1'b0;
                    qfc_next[thr_reg] = qfc_reg[thr_reg] + 6'd1;
                    if (!fb_reg[mq_rd_reg.ptag])
                    begin
                        fb_next[mq_rd_reg.ptag] = 1'b1;
                        fcnt_next = fcnt_reg + 8'd1;
                    end
                end
                else if (!byblk_reg && mq_same)
                begin
                    // Survivors of the flushed block are replayed into the map.
                    spec_we = 1'b1;
                    spec_vld_next[{thr_reg, mq_rd_reg.areg}] = 1'b1;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            ST_EMIT:
            begin
                push = can_push;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 6'd0;
            fb_reg       <= {{(NUM_PTAGS - THREADS * ARCH_REGS){1'b1}},
                             {(THREADS * ARCH_REGS){1'b0}}};
            fcnt_reg     <= 8'(NUM_PTAGS - THREADS * ARCH_REGS);
            qvld_reg     <= '0;
            spec_vld_reg <= '0;
            cm_vld_reg   <= '0;
            cvalid_reg   <= '0;
            pend_reg     <= 1'b0;
            for (int t = 0; t < THREADS; t++)
            begin
                qfc_reg[t]     <= 6'(MAPQ_DEPTH);
                rp_idx_reg[t]  <= 4'd0;
                rp_wrap_reg[t] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fb_reg       <= fb_next;
            fcnt_reg     <= fcnt_next;
            qvld_reg     <= qvld_next;
            spec_vld_reg <= spec_vld_next;
            cm_vld_reg   <= cm_vld_next;
            cvalid_reg   <= cvalid_next;
            pend_reg     <= pend_next;
            qfc_reg      <= qfc_next;
            rp_idx_reg   <= rp_idx_next;
            rp_wrap_reg  <= rp_wrap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            thr_reg   <= thread;
            ar_reg    <= arch_reg;
            bi_reg    <= block_id;
            bw_reg    <= block_wrap;
            rid_reg   <= inst_rid;
            byblk_reg <= flush_by_block;
            need_reg  <= need_count;
        end
        tag_reg      <= tag_next;
        slot_reg     <= slot_next;
        pend_tag_reg <= pend_tag_next;
        src_ck_reg   <= src_ck_next;
        res_reg      <= res_next;
    end

    // Map memories, checkpoint store and map queue: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (spec_we)
        begin
            spec_mem[spec_waddr] <= spec_wdata;
        end
        if (spec_re)
        begin
            spec_rd_reg <= spec_mem[spec_raddr];
            spec_rv_reg <= spec_vld_reg[spec_raddr];
            spec_ra_reg <= spec_raddr;
        end
        if (cm_we)
        begin
            cm_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rd_reg <= cm_mem[cm_raddr];
            cm_rv_reg <= cm_vld_reg[cm_raddr];
            cm_ra_reg <= cm_raddr;
        end
        if (ckpt_we)
        begin
            ckpt_mem[ckpt_waddr] <= ckpt_wdata;
        end
        if (ckpt_re)
        begin
            ckpt_rd_reg <= ckpt_mem[ckpt_raddr];
        end
        if (mq_we)
        begin
            mq_mem[mq_waddr] <= mq_wdata;
        end
        if (mq_re)
        begin
            mq_rd_reg <= mq_mem[mq_raddr];
        end
    end

    rru_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .can_push (can_push),
        .stall    (out_stall),
        .valid    (out_valid),
        .res      (obuf_res)
    );

    assign phys_tag  = obuf_res.tag;
    assign tag_valid = obuf_res.tvld;
    assign stall_res = obuf_res.st;
    assign last      = obuf_res.last;

endmodule

### verif/tb_top.sv
// Self-checking testbench for register_rename_unit_top: a built-in rename
// predictor, a result checker and directed and random operation tests.
// Depends on rru_pkg and the RTL of the rename unit.
`timescale 1ns / 1ps

module tb_top;
    import rru_pkg::*;

    typedef struct {
        logic [6:0] tag;
        logic       tvld;
        logic       st;
        logic       last;
    } rename_res_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] func;
    logic       thread;
    logic [4:0] arch_reg;
    logic [3:0] block_id;
    logic       block_wrap;
    logic [5:0] inst_rid;
    logic       flush_by_block;
    logic [5:0] need_count;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] phys_tag;
    logic       tag_valid;
    logic       stall_res;
    logic       last;

    register_rename_unit_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .thread(thread), .arch_reg(arch_reg), .block_id(block_id),
        .block_wrap(block_wrap), .inst_rid(inst_rid),
        .flush_by_block(flush_by_block), .need_count(need_count),
        .out_valid(out_valid), .out_stall(out_stall), .phys_tag(phys_tag),
        .tag_valid(tag_valid), .stall_res(stall_res), .last(last)
    );

    // Predicted rename state.
    logic [6:0] spec_tbl [THREADS][ARCH_REGS];
    logic [6:0] arch_tbl [THREADS][ARCH_REGS];
    logic       tag_free [NUM_PTAGS];
    int         tags_free_n;
    logic [6:0] snap_tbl [THREADS][ROB_DEPTH][ARCH_REGS];
    logic       snap_ok  [THREADS][ROB_DEPTH];
    logic       dq_vld   [THREADS][MAPQ_DEPTH];
    logic [4:0] dq_areg  [THREADS][MAPQ_DEPTH];
    logic [6:0] dq_ptag  [THREADS][MAPQ_DEPTH];
    logic [3:0] dq_bidx  [THREADS][MAPQ_DEPTH];
    logic       dq_wrap  [THREADS][MAPQ_DEPTH];
    logic [5:0] dq_rid   [THREADS][MAPQ_DEPTH];
    int         slots_free_n [THREADS];
    logic [3:0] ren_idx  [THREADS];
    logic       ren_wrap [THREADS];

    rename_res_t pending_res[$];
    int          mismatches;
    int          hold_cycles;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic not_younger(input logic [3:0] ai, input logic aw,
                                         input logic [3:0] bi, input logic bw);
        if (aw == bw)
        begin
            return ai <= bi;
        end
        return ai > bi;
    endfunction

    function automatic rename_res_t mk_res(input logic [6:0] tg, input logic v,
                                           input logic s, input logic l);
        rename_res_t r;
        r.tag  = tg;
        r.tvld = v;
        r.st   = s;
        r.last = l;
        return r;
    endfunction

    task automatic rename_state_reset();
        for (int t = 0; t < THREADS; t++)
        begin
            for (int r = 0; r < ARCH_REGS; r++)
            begin
                spec_tbl[t][r] = 7'(t * ARCH_REGS + r);
                arch_tbl[t][r] = 7'(t * ARCH_REGS + r);
            end
            for (int i = 0; i < MAPQ_DEPTH; i++)
            begin
                dq_vld[t][i] = 1'b0;
            end
            for (int b = 0; b < ROB_DEPTH; b++)
            begin
                snap_ok[t][b] = 1'b0;
            end
            slots_free_n[t] = MAPQ_DEPTH;
            ren_idx[t] = '0;
            ren_wrap[t] = 1'b0;
        end
        for (int p = 0; p < NUM_PTAGS; p++)
        begin
            tag_free[p] = (p >= THREADS * ARCH_REGS);
        end
        tags_free_n = NUM_PTAGS - THREADS * ARCH_REGS;
    endtask

    task automatic release_tag(input logic [6:0] tg);
        if (!tag_free[tg])
        begin
            tag_free[tg] = 1'b1;
            tags_free_n++;
        end
    endtask

    // Applies one operation to the predicted state and queues its result beats.
    task automatic rename_predict(input logic [2:0] f, input logic t, input logic [4:0] ar,
                                  input logic [3:0] bi, input logic bw, input logic [5:0] rid,
                                  input logic byblk, input logic [5:0] need);
        int tg;
        int sl;
        int n;
        logic [3:0] yi;
        logic yw;
        logic kill;
        tg = -1;
        sl = -1;
        n = 0;
        case (f)
            FN_SRC:
                pending_res.push_back(mk_res(spec_tbl[t][ar], 1'b1, 1'b0, 1'b1));
            FN_COMMIT:
                pending_res.push_back(mk_res(arch_tbl[t][ar], 1'b1, 1'b0, 1'b1));
            FN_ALLOC:
            begin
                for (int i = NUM_PTAGS - 1; i >= 0; i--)
                begin
                    if (tag_free[i])
                    begin
                        tg = i;
                    end
                end
                for (int i = MAPQ_DEPTH - 1; i >= 0; i--)
                begin
                    if (!dq_vld[t][i])
                    begin
                        sl = i;
                    end
                end
                if (tg < 0 || sl < 0)
                begin
                    pending_res.push_back(mk_res('0, 1'b0, 1'b0, 1'b1));
                end
                else
                begin
                    tag_free[tg] = 1'b0;
                    tags_free_n--;
                    spec_tbl[t][ar] = 7'(tg);
                    dq_vld[t][sl] = 1'b1;
                    dq_areg[t][sl] = ar;
                    dq_ptag[t][sl] = 7'(tg);
                    dq_bidx[t][sl] = bi;
                    dq_wrap[t][sl] = bw;
                    dq_rid[t][sl] = rid;
                    slots_free_n[t]--;
                    pending_res.push_back(mk_res(7'(tg), 1'b1, 1'b0, 1'b1));
                end
            end
            FN_CKPT:
            begin
                snap_tbl[t][bi] = spec_tbl[t];
                snap_ok[t][bi] = 1'b1;
                ren_idx[t] = bi;
                ren_wrap[t] = bw;
                pending_res.push_back(mk_res('0, 1'b0, 1'b0, 1'b1));
            end
            FN_RETIRE:
            begin
                for (int i = 0; i < MAPQ_DEPTH; i++)
                begin
                    if (dq_vld[t][i] && dq_bidx[t][i] == bi && dq_wrap[t][i] == bw)
                    begin
                        release_tag(arch_tbl[t][dq_areg[t][i]]);
                        pending_res.push_back(mk_res(arch_tbl[t][dq_areg[t][i]],
                                                     1'b1, 1'b0, 1'b0));
                        n++;
                        arch_tbl[t][dq_areg[t][i]] = dq_ptag[t][i];
                        dq_vld[t][i] = 1'b0;
                        slots_free_n[t]++;
                    end
                end
                if (n == 0)
                begin
                    pending_res.push_back(mk_res('0, 1'b0, 1'b0, 1'b1));
                end
                else
                begin
                    pending_res[$].last = 1'b1;
                end
            end
            FN_FLUSH:
            begin
                yi = bi - 4'd1;
                yw = (bi == 4'd0) ? ~bw : bw;
                if (not_younger(yi, yw, ren_idx[t], ren_wrap[t]))
                begin
                    ren_idx[t] = yi;
                    ren_wrap[t] = yw;
                    if (snap_ok[t][yi])
                    begin
                        spec_tbl[t] = snap_tbl[t][yi];
                    end
                    else
                    begin
                        spec_tbl[t] = arch_tbl[t];
                    end
                end
                for (int i = 0; i < MAPQ_DEPTH; i++)
                begin
                    if (dq_vld[t][i])
                    begin
                        if (!byblk && dq_bidx[t][i] == bi && dq_wrap[t][i] == bw)
                        begin
                            kill = rid <= dq_rid[t][i];
                        end
                        else
                        begin
                            kill = not_younger(bi, bw, dq_bidx[t][i], dq_wrap[t][i]);
                        end
                        if (kill)
                        begin
                            release_tag(dq_ptag[t][i]);
                            dq_vld[t][i] = 1'b0;
                            slots_free_n[t]++;
                        end
                    end
                    if (dq_vld[t][i] && !byblk && dq_bidx[t][i] == bi && dq_wrap[t][i] == bw)
                    begin
                        spec_tbl[t][dq_areg[t][i]] = dq_ptag[t][i];
                    end
                end
                pending_res.push_back(mk_res('0, 1'b0, 1'b0, 1'b1));
            end
            FN_STALL:
                pending_res.push_back(mk_res('0, 1'b0,
                    (tags_free_n < need) || (slots_free_n[t] < need), 1'b1));
            default:
                pending_res.push_back(mk_res('0, 1'b0, 1'b0, 1'b1));
        endcase
    endtask

    // Offers one operation beat and predicts it once accepted. Bursts and
    // gaps are drawn here; valid stays high between beats of one burst.
    task automatic send_op(input logic [2:0] f, input logic t, input logic [4:0] ar,
                           input logic [3:0] bi, input logic bw, input logic [5:0] rid,
                           input logic byblk, input logic [5:0] need);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        func <= f;
        thread <= t;
        arch_reg <= ar;
        block_id <= bi;
        block_wrap <= bw;
        inst_rid <= rid;
        flush_by_block <= byblk;
        need_count <= need;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        rename_predict(f, t, ar, bi, bw, rid, byblk, need);
        burst_left--;
    endtask

    task automatic test_lookups();
        send_op(FN_SRC, 1'b0, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_SRC, 1'b1, 5'd31, 4'd15, 1'b1, 6'd63, 1'b1, 6'd32);
        send_op(FN_COMMIT, 1'b1, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_COMMIT, 1'b0, 5'd31, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(3'd7, 1'b1, 5'd31, 4'd15, 1'b1, 6'd63, 1'b1, 6'd32);
    endtask

    task automatic test_stall_check();
        send_op(FN_STALL, 1'b0, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_STALL, 1'b1, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd32);
        send_op(FN_STALL, 1'b0, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd31);
    endtask

    task automatic test_alloc_retire();
        send_op(FN_ALLOC, 1'b0, 5'd3, 4'd1, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_ALLOC, 1'b0, 5'd3, 4'd1, 1'b0, 6'd1, 1'b0, 6'd0);
        send_op(FN_ALLOC, 1'b0, 5'd31, 4'd1, 1'b0, 6'd2, 1'b0, 6'd0);
        send_op(FN_RETIRE, 1'b0, 5'd0, 4'd1, 1'b0, 6'd0, 1'b0, 6'd0);
        // Nothing queued for this block: a single empty beat.
        send_op(FN_RETIRE, 1'b0, 5'd0, 4'd1, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_COMMIT, 1'b0, 5'd3, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
    endtask

    task automatic test_checkpoint_flush();
        send_op(FN_CKPT, 1'b1, 5'd0, 4'd2, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_ALLOC, 1'b1, 5'd5, 4'd3, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_CKPT, 1'b1, 5'd0, 4'd3, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_ALLOC, 1'b1, 5'd6, 4'd3, 1'b0, 6'd5, 1'b0, 6'd0);
        send_op(FN_ALLOC, 1'b1, 5'd7, 4'd3, 1'b0, 6'd9, 1'b0, 6'd0);
        send_op(FN_FLUSH, 1'b1, 5'd0, 4'd3, 1'b0, 6'd6, 1'b0, 6'd0);
        send_op(FN_SRC, 1'b1, 5'd6, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_FLUSH, 1'b1, 5'd0, 4'd0, 1'b0, 6'd0, 1'b1, 6'd0);
        send_op(FN_SRC, 1'b1, 5'd5, 4'd0, 1'b0, 6'd0, 1'b0, 6'd0);
    endtask

    // Fills thread 0's queue past its depth, then thread 1's, which drains the free tags.
    task automatic test_exhaustion();
        for (int i = 0; i < MAPQ_DEPTH + 1; i++)
        begin
            send_op(FN_ALLOC, 1'b0, 5'($urandom), 4'd4, 1'b0, 6'(i), 1'b0, 6'd0);
        end
        for (int i = 0; i < MAPQ_DEPTH + 1; i++)
        begin
            send_op(FN_ALLOC, 1'b1, 5'($urandom), 4'd5, 1'b1, 6'(i), 1'b0, 6'd0);
        end
        send_op(FN_STALL, 1'b1, 5'd0, 4'd0, 1'b0, 6'd0, 1'b0, 6'd1);
        send_op(FN_RETIRE, 1'b0, 5'd0, 4'd4, 1'b0, 6'd0, 1'b0, 6'd0);
        send_op(FN_FLUSH, 1'b1, 5'd0, 4'd5, 1'b1, 6'd0, 1'b1, 6'd0);
    endtask

    // Holds the result side for a long stretch while operations keep coming.
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 6; i++)
        begin
            send_op(FN_ALLOC, 1'($urandom), 5'($urandom), 4'd6, 1'b0, 6'(i), 1'b0, 6'd0);
        end
        send_op(FN_RETIRE, 1'b0, 5'd0, 4'd6, 1'b0, 6'd0, 1'b0, 6'd0);
    endtask

    task automatic test_random(input int count);
        logic [2:0] f;
        logic t;
        logic [3:0] bi;
        logic bw;
        int pick;
        int sl;
        for (int k = 0; k < count; k++)
        begin
            t = 1'($urandom);
            bi = 4'($urandom);
            bw = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35)      f = FN_ALLOC;
            else if (pick < 45) f = FN_SRC;
            else if (pick < 53) f = FN_CKPT;
            else if (pick < 70) f = FN_RETIRE;
            else if (pick < 80) f = FN_FLUSH;
            else if (pick < 88) f = FN_STALL;
            else if (pick < 97) f = FN_COMMIT;
            else                f = 3'd7;
            // Most retires and flushes target a block that has queued work.
            if ((f == FN_RETIRE || f == FN_FLUSH) && $urandom_range(0, 4) != 0)
            begin
                sl = $urandom_range(0, MAPQ_DEPTH - 1);
                for (int i = 0; i < MAPQ_DEPTH; i++)
                begin
                    if (dq_vld[t][(sl + i) % MAPQ_DEPTH])
                    begin
                        bi = dq_bidx[t][(sl + i) % MAPQ_DEPTH];
                        bw = dq_wrap[t][(sl + i) % MAPQ_DEPTH];
                        break;
                    end
                end
            end
            else if (f == FN_ALLOC && $urandom_range(0, 3) != 0)
            begin
                bi = ren_idx[t];
                bw = ren_wrap[t];
            end
            send_op(f, t, 5'($urandom), bi, bw, 6'($urandom), 1'($urandom),
                    6'($urandom_range(0, 32)));
        end
    endtask

    // Result side: its own stall pattern plus an occasional long hold.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 15) != 0);
        end
    end

    // Checks each accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat tag=%0d v=%0b st=%0b last=%0b",
                             phys_tag, tag_valid, stall_res, last);
                end
            end
            else
            begin
                if (phys_tag !== pending_res[0].tag || tag_valid !== pending_res[0].tvld
                    || stall_res !== pending_res[0].st || last !== pending_res[0].last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"result beat: expected tag=%0d v=%0b st=%0b last=%0b,",
                                  " got tag=%0d v=%0b st=%0b last=%0b"},
                                 pending_res[0].tag, pending_res[0].tvld, pending_res[0].st,
                                 pending_res[0].last, phys_tag, tag_valid, stall_res, last);
                    end
                end
                void'(pending_res.pop_front());
            end
        end
    end

    initial
    begin
        #5ms;
        $display("register_rename_unit_top: mismatch");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        hold_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = '0;
        thread = 1'b0;
        arch_reg = '0;
        block_id = '0;
        block_wrap = 1'b0;
        inst_rid = '0;
        flush_by_block = 1'b0;
        need_count = '0;
        rename_state_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lookups();
        test_stall_check();
        test_alloc_retire();
        test_checkpoint_flush();
        test_exhaustion();
        test_backpressure();
        test_random(262);
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_res.size() == 0)
        begin
            $display("register_rename_unit_top: match");
        end
        else
        begin
            $display("register_rename_unit_top: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rru_pkg.sv
rtl/rru_obuf.sv
rtl/register_rename_unit_top.sv
verif/tb_top.sv
